FILE: rtl/core/drs_pkg.sv
// Shared types and constants of the dependency release scoreboard.
`default_nettype none

package drs_pkg;

    localparam int REQ_W     = 2;
    localparam int IDX_W     = 6;
    localparam int CNT_W     = 7;
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 8;

    typedef enum logic [REQ_W-1:0] {
        REQ_EDGE     = 2'd0,
        REQ_COMPLETE = 2'd1,
        REQ_CLEAR    = 2'd2
    } req_type_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_RESULT
    } state_t;

    // Per-cell command; all fields but clr are already qualified by the cell's own select.
    typedef struct packed {
        logic clr;
        logic add_edge;
        logic complete;
        logic make_pending;
    } cell_cmd_t;

    // What one cell hands to the next: the sweep token and the changed flag.
    typedef struct packed {
        logic tok;
        logic chg;
    } link_t;

endpackage

`default_nettype wire

FILE: rtl/core/dependency_release_scoreboard.sv
// Top level of the dependency release scoreboard: item decode, sweep control and output word.
//
// Usage. Words arrive on the slave stream. s_tuser carries the item kind (edge, request,
// clear); s_tdata carries the prerequisite and target node numbers. Only request words
// produce a result: one master-stream word holding the running count of completed nodes.
// Edge and clear words leave the block idle and produce nothing.
// Each node lives in a cell of a chain. A request whose node completes while other nodes
// are pending starts a sweep: a token walks the chain one cell per cycle, and the cell
// holding it completes if it is pending and all of its prerequisites are complete. A sweep
// is repeated until a whole sweep completes nothing; there are at most NODES sweeps. A
// request that completes nothing, or leaves no other node pending, goes straight to the
// result state; otherwise the result follows the last sweep. One item is worked on at a
// time; s_tready is high while idle.
// The result sits in an output register, so the block goes back to idle and accepts
// further words while the previous result waits for m_tready. A new request whose result
// is due while the output register is still full holds until the receiver takes the word.
// Reset, like a clear word, empties all prerequisite rows, flags and the count at once.
`default_nettype none

module dependency_release_scoreboard #(
    parameter int NODES = 64
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             s_tvalid,
    output logic                                  s_tready,
    // [5:0] prereq_index, [11:6] target_index, [15:12] zero
    input  wire logic [drs_pkg::S_TDATA_W-1:0]    s_tdata,
    // [1:0] req_type
    input  wire logic [drs_pkg::REQ_W-1:0]        s_tuser,
    output logic                                  m_tvalid,
    input  wire logic                             m_tready,
    // [6:0] completed_count, [7] zero
    output logic [drs_pkg::M_TDATA_W-1:0]         m_tdata
);

    logic [drs_pkg::IDX_W-1:0] prereq_index;
    logic [drs_pkg::IDX_W-1:0] target_index;

    drs_pkg::state_t state_reg, state_next;
    logic [drs_pkg::CNT_W-1:0] count_reg, count_next;
    logic                      out_valid_reg, out_valid_next;
    logic [drs_pkg::CNT_W-1:0] out_count_reg, out_count_next;

    logic [NODES-1:0] sel_vec;
    logic [NODES-1:0] pre_vec;
    logic [NODES-1:0] comp_vec;
    logic [NODES-1:0] pend_vec;
    logic [NODES-1:0] ready_vec;
    logic [NODES-1:0] fire_vec;
    drs_pkg::link_t   link_w [NODES+1];
    drs_pkg::cell_cmd_t cmd_w [NODES];

    logic accept, is_edge, is_req, is_clr;
    logic tgt_open, tgt_ready, req_done, others_pending, any_fire;
    logic start, load_out;

    assign prereq_index = s_tdata[drs_pkg::IDX_W-1:0];
    assign target_index = s_tdata[2*drs_pkg::IDX_W-1:drs_pkg::IDX_W];

    assign accept  = s_tvalid & s_tready;
    assign is_edge = accept & (s_tuser == drs_pkg::REQ_EDGE);
    assign is_req  = accept & (s_tuser == drs_pkg::REQ_COMPLETE);
    assign is_clr  = accept & (s_tuser == drs_pkg::REQ_CLEAR);

    // Node numbers at or beyond NODES decode to no cell at all.
    always_comb
    begin
        for (int i = 0; i < NODES; i++)
        begin
            sel_vec[i] = (32'(target_index) == i);
            pre_vec[i] = (32'(prereq_index) == i);
        end
    end

    assign tgt_open       = |(sel_vec & ~comp_vec);
    assign tgt_ready      = |(sel_vec & ready_vec);
    assign req_done       = is_req & tgt_open & tgt_ready;
    assign others_pending = |(pend_vec & ~sel_vec);
    assign any_fire       = |fire_vec;

    always_comb
    begin
        for (int i = 0; i < NODES; i++)
        begin
            cmd_w[i].clr          = is_clr;
            cmd_w[i].add_edge     = is_edge & sel_vec[i];
            cmd_w[i].complete     = req_done & sel_vec[i];
            cmd_w[i].make_pending = is_req & tgt_open & ~tgt_ready & sel_vec[i];
        end
    end

    // The sweep token enters the chain at the first cell.
    assign link_w[0].tok = start;
    assign link_w[0].chg = 1'b0;

    genvar g;
    generate
        for (g = 0; g < NODES; g++)
        begin : g_cell
            drs_cell #(
                .NODES (NODES)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd_w[g]),
                .pre_sel   (pre_vec),
                .comp_vec  (comp_vec),
                .link_in   (link_w[g]),
                .link_out  (link_w[g+1]),
                .completed (comp_vec[g]),
                .pending   (pend_vec[g]),
                .ready     (ready_vec[g]),
                .fire      (fire_vec[g])
            );
        end
    endgenerate

    // At most one node completes per cycle, so the count moves by one at a time.
    always_comb
    begin
        if (is_clr)
        begin
            count_next = '0;
        end
        else if (req_done || any_fire)
        begin
            count_next = count_reg + drs_pkg::CNT_W'(1);
        end
        else
        begin
            count_next = count_reg;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        start      = 1'b0;
        load_out   = 1'b0;
        s_tready   = 1'b0;
        unique case (state_reg)
            drs_pkg::ST_IDLE:
            begin
                s_tready = 1'b1;
                if (is_req)
                begin
                    if (req_done && others_pending)
                    begin
                        start      = 1'b1;
                        state_next = drs_pkg::ST_SWEEP;
                    end
                    else
                    begin
                        state_next = drs_pkg::ST_RESULT;
                    end
                end
            end
            drs_pkg::ST_SWEEP:
            begin
                // The token is in the last cell: repeat the sweep if anything changed.
                if (link_w[NODES].tok)
                begin
                    if (link_w[NODES].chg)
                    begin
                        start = 1'b1;
                    end
                    else
                    begin
                        state_next = drs_pkg::ST_RESULT;
                    end
                end
            end
            drs_pkg::ST_RESULT:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = drs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = drs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_count_next = out_count_reg;
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_count_next = count_reg;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= drs_pkg::ST_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_count_reg <= out_count_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = drs_pkg::M_TDATA_W'(out_count_reg);

endmodule

`default_nettype wire

FILE: rtl/core/drs_cell.sv
// One node of the scoreboard: its prerequisite row, its flags and its sweep stage.
`default_nettype none

module drs_cell #(
    parameter int NODES = 64
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire drs_pkg::cell_cmd_t cmd,
    input  wire logic [NODES-1:0]  pre_sel,
    input  wire logic [NODES-1:0]  comp_vec,
    input  wire drs_pkg::link_t    link_in,
    output drs_pkg::link_t         link_out,
    output logic                   completed,
    output logic                   pending,
    output logic                   ready,
    output logic                   fire
);

    logic [NODES-1:0] mask_reg, mask_next;
    logic             completed_reg, completed_next;
    logic             pending_reg, pending_next;
    drs_pkg::link_t   link_reg, link_next;

    // The node may complete once every prerequisite in its row has completed.
    assign ready = ~|(mask_reg & ~comp_vec);
    // The node completes on its turn in a sweep if it is still waiting and ready.
    assign fire  = link_reg.tok & pending_reg & ~completed_reg & ready;

    always_comb
    begin
        mask_next      = mask_reg;
        completed_next = completed_reg;
        pending_next   = pending_reg;
        link_next      = link_in;
        if (cmd.clr)
        begin
            mask_next      = '0;
            completed_next = 1'b0;
            pending_next   = 1'b0;
            link_next      = '0;
        end
        else
        begin
            if (cmd.add_edge)
            begin
                mask_next = mask_reg | pre_sel;
            end
            if (cmd.complete || fire)
            begin
                completed_next = 1'b1;
                pending_next   = 1'b0;
            end
            else if (cmd.make_pending)
            begin
                pending_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg      <= '0;
            completed_reg <= 1'b0;
            pending_reg   <= 1'b0;
            link_reg      <= '0;
        end
        else
        begin
            mask_reg      <= mask_next;
            completed_reg <= completed_next;
            pending_reg   <= pending_next;
            link_reg      <= link_next;
        end
    end

    assign link_out.tok = link_reg.tok;
    assign link_out.chg = link_reg.chg | fire;
    assign completed    = completed_reg;
    assign pending      = pending_reg;

endmodule

`default_nettype wire

FILE: rtl/core/drs_checker.sv
// Port-level checks on the dependency release scoreboard, bound to the top level.
`default_nettype none

module drs_checker #(
    parameter int NODES = 64
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [drs_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic [drs_pkg::REQ_W-1:0]     s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [drs_pkg::M_TDATA_W-1:0] m_tdata
);

    // A stalled result word stays offered.
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result word withdrawn while stalled");

    // The count never exceeds the number of nodes.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (NODES > 127) || (32'(m_tdata[drs_pkg::CNT_W-1:0]) <= NODES))
        else $error("completed count beyond node count");

    // Edge and clear words leave the block idle, so it is ready again in the next cycle.
    a_short_items: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready &&
        (s_tuser == drs_pkg::REQ_EDGE || s_tuser == drs_pkg::REQ_CLEAR) |=> s_tready)
        else $error("edge or clear word held the input");

    // A request is never finished in the cycle of its acceptance.
    a_req_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tuser == drs_pkg::REQ_COMPLETE |=> !s_tready)
        else $error("input ready while a request is in progress");

endmodule

bind dependency_release_scoreboard drs_checker #(
    .NODES (NODES)
) u_drs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

FILE: sim/tb.sv
// Self-checking testbench for the dependency release scoreboard: directed table, then random graphs.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import drs_pkg::*;

    localparam int NODES = 64;

    // The one req_type value that the block ignores; it has no member in the package enum.
    localparam logic [REQ_W-1:0] REQ_SPARE = 2'd3;

    // Useful words (everything but the ignored kind) in the whole run.
    localparam int ITEM_TARGET = 1600;

    // The slowest request runs NODES sweeps of the whole chain.
    // Add the long receiver hold-off and the longest sender gap, then allow four times that.
    localparam int QUIET_LIMIT = 20000;
    localparam int LONG_HOLD   = 600;
    localparam int TAIL_CYCLES = 4 * NODES;

    // One input word together with what the run needs to know about it.
    typedef struct packed {
        logic [REQ_W-1:0] kind;
        logic [IDX_W-1:0] pre;
        logic [IDX_W-1:0] tgt;
        logic             known;   // answer below is typed in, not taken from the predictor
        logic [CNT_W-1:0] answer;
        logic             drain;   // hold this word back until every count has come out
    } row_t;

    // Directed opening: extremes of both node numbers, every kind, repeated requests,
    // a self edge, a cascade in rising order and one that needs several sweeps, and clears.
    localparam row_t DIRECTED [25] = '{
        '{REQ_CLEAR,    6'd0,  6'd0,  1'b0, 7'd0, 1'b0},
        '{REQ_COMPLETE, 6'd0,  6'd0,  1'b1, 7'd1, 1'b0},
        '{REQ_COMPLETE, 6'd63, 6'd0,  1'b1, 7'd1, 1'b0},
        '{REQ_COMPLETE, 6'd0,  6'd63, 1'b1, 7'd2, 1'b0},
        '{REQ_EDGE,     6'd5,  6'd5,  1'b0, 7'd0, 1'b0},
        '{REQ_COMPLETE, 6'd0,  6'd5,  1'b1, 7'd2, 1'b0},
        '{REQ_SPARE,    6'd63, 6'd63, 1'b0, 7'd0, 1'b0},
        '{REQ_EDGE,     6'd63, 6'd62, 1'b0, 7'd0, 1'b0},
        '{REQ_COMPLETE, 6'd0,  6'd62, 1'b0, 7'd0, 1'b0},
        '{REQ_EDGE,     6'd10, 6'd11, 1'b0, 7'd0, 1'b0},
        '{REQ_EDGE,     6'd11, 6'd12, 1'b0, 7'd0, 1'b0},
        '{REQ_COMPLETE, 6'd0,  6'd12, 1'b0, 7'd0, 1'b0},
        '{REQ_COMPLETE, 6'd0,  6'd11, 1'b0, 7'd0, 1'b0},
        '{REQ_COMPLETE, 6'd0,  6'd10, 1'b0, 7'd0, 1'b0},
        '{REQ_EDGE,     6'd3,  6'd2,  1'b0, 7'd0, 1'b0},
        '{REQ_EDGE,     6'd2,  6'd1,  1'b0, 7'd0, 1'b0},
        '{REQ_COMPLETE, 6'd0,  6'd1,  1'b0, 7'd0, 1'b0},
        '{REQ_COMPLETE, 6'd0,  6'd2,  1'b0, 7'd0, 1'b0},
        '{REQ_COMPLETE, 6'd0,  6'd3,  1'b0, 7'd0, 1'b0},
        '{REQ_EDGE,     6'd42, 6'd21, 1'b0, 7'd0, 1'b0},
        '{REQ_COMPLETE, 6'd0,  6'd21, 1'b0, 7'd0, 1'b0},
        '{REQ_SPARE,    6'd21, 6'd42, 1'b0, 7'd0, 1'b0},
        '{REQ_CLEAR,    6'd63, 6'd63, 1'b0, 7'd0, 1'b0},
        '{REQ_COMPLETE, 6'd0,  6'd21, 1'b1, 7'd1, 1'b0},
        '{REQ_COMPLETE, 6'd0,  6'd42, 1'b1, 7'd2, 1'b0}
    };

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // [5:0] prereq_index, [11:6] target_index, [15:12] zero
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    // [1:0] req_type
    logic [REQ_W-1:0]     s_tuser  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // [6:0] completed_count, [7] zero
    logic [M_TDATA_W-1:0] m_tdata;

    dependency_release_scoreboard #(
        .NODES (NODES)
    ) u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: the testbench's own copy of the graph and the completion state.
    // ------------------------------------------------------------------
    bit [NODES-1:0] needs_row [NODES];
    bit [NODES-1:0] finished_set;
    bit [NODES-1:0] waiting_set;
    bit [CNT_W-1:0] finished_total;

    row_t           stim [$];
    bit [CNT_W-1:0] due_counts [$];
    int             useful_words;
    bit             noise_on;
    int             mismatches;
    int             quiet_cycles;

    function automatic bit node_ready(int unsigned n);
        return (needs_row[n] & ~finished_set) == '0;
    endfunction

    function automatic void mark_finished(int unsigned n);
        finished_set[n] = 1'b1;
        waiting_set[n]  = 1'b0;
        finished_total  = finished_total + CNT_W'(1);
    endfunction

    // Applies one accepted word to the copy of the state; a request also yields its count.
    function automatic void predict_release(input row_t w, output bit answers,
                                            output bit [CNT_W-1:0] total);
        bit swept;
        answers = 1'b0;
        total   = finished_total;
        case (w.kind)
            REQ_EDGE:
                needs_row[w.tgt][w.pre] = 1'b1;
            REQ_CLEAR:
            begin
                foreach (needs_row[i])
                    needs_row[i] = '0;
                finished_set   = '0;
                waiting_set    = '0;
                finished_total = '0;
            end
            REQ_COMPLETE:
            begin
                if (!finished_set[w.tgt])
                begin
                    if (node_ready(w.tgt))
                    begin
                        mark_finished(w.tgt);
                        // Keep sweeping until a whole pass releases nothing more.
                        swept = 1'b1;
                        while (swept)
                        begin
                            swept = 1'b0;
                            for (int i = 0; i < NODES; i++)
                            begin
                                if (waiting_set[i] && !finished_set[i] && node_ready(i))
                                begin
                                    mark_finished(i);
                                    swept = 1'b1;
                                end
                            end
                        end
                    end
                    else
                    begin
                        waiting_set[w.tgt] = 1'b1;
                    end
                end
                answers = 1'b1;
                total   = finished_total;
            end
            default:
                ;
        endcase
    endfunction

    // Appends one word, now and then preceded by a stray one of random kind and content.
    function automatic void push_word(logic [REQ_W-1:0] kind, logic [IDX_W-1:0] pre,
                                      logic [IDX_W-1:0] tgt, bit drain);
        row_t w;
        if (noise_on && $urandom_range(0, 11) == 0)
        begin
            w = '0;
            w.kind = REQ_W'($urandom_range(0, 3));
            // Stray clears would wipe out most sequences, so keep them rare.
            if (w.kind == REQ_CLEAR && $urandom_range(0, 7) != 0)
                w.kind = REQ_SPARE;
            w.pre = IDX_W'($urandom_range(0, NODES - 1));
            w.tgt = IDX_W'($urandom_range(0, NODES - 1));
            stim.push_back(w);
            if (w.kind != REQ_SPARE)
                useful_words++;
        end
        w       = '0;
        w.kind  = kind;
        w.pre   = pre;
        w.tgt   = tgt;
        w.drain = drain;
        stim.push_back(w);
        if (kind != REQ_SPARE)
            useful_words++;
    endfunction

    // ------------------------------------------------------------------
    // Result checking: every count word against the oldest expectation.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (due_counts.size() == 0)
            begin
                $display("%0t: unexpected count word, actual %0d", $realtime,
                         m_tdata[CNT_W-1:0]);
                mismatches++;
            end
            else if (m_tdata[CNT_W-1:0] != due_counts[0])
            begin
                $display("%0t: completed_count mismatch, expected %0d, actual %0d",
                         $realtime, due_counts[0], m_tdata[CNT_W-1:0]);
                mismatches++;
                void'(due_counts.pop_front());
            end
            else
            begin
                void'(due_counts.pop_front());
            end
        end
    end

    // Watchdog: ends the run once nothing has moved on either stream for too long.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: changes stall pattern every so often, and once holds off for a long stretch
    // so that the output register fills and the block has to refuse new words.
    // ------------------------------------------------------------------
    initial
    begin
        int  mode;
        int  left;
        int  hold_left;
        int  phase;
        int  taken;
        bit  held;
        mode      = 0;
        left      = 0;
        hold_left = 0;
        phase     = 0;
        taken     = 0;
        held      = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
                taken++;
            if (!held && taken >= 40)
            begin
                held      = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                if (left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    left = $urandom_range(20, 200);
                end
                left--;
                phase++;
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (phase % 4) != 0;
                    default: m_tready <= $urandom_range(0, 4) == 0;
                endcase
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus, reset, sender and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        int             sent;
        int             gap_left;
        int             burst_left;
        int             n;
        int             edges;
        int             requests;
        int             a;
        int             b;
        int             picks [NODES];
        bit             answers;
        bit [CNT_W-1:0] total;

        mismatches     = 0;
        quiet_cycles   = 0;
        useful_words   = 0;
        finished_set   = '0;
        waiting_set    = '0;
        finished_total = '0;
        foreach (needs_row[i])
            needs_row[i] = '0;

        noise_on = 1'b0;
        for (int i = 0; i < $size(DIRECTED); i++)
            push_word(DIRECTED[i].kind, DIRECTED[i].pre, DIRECTED[i].tgt, 1'b0);
        // The typed-in answers travel with their rows.
        for (int i = 0; i < $size(DIRECTED); i++)
        begin
            stim[i].known  = DIRECTED[i].known;
            stim[i].answer = DIRECTED[i].answer;
        end

        // The deepest case: every node waits on the next one up, all are requested, and then
        // the top node releases the lot, one node per sweep, up to a count of NODES.
        push_word(REQ_CLEAR, '0, '0, 1'b1);
        for (int i = 0; i < NODES - 1; i++)
            push_word(REQ_EDGE, IDX_W'(i + 1), IDX_W'(i), 1'b0);
        for (int i = 0; i < NODES - 1; i++)
            push_word(REQ_COMPLETE, IDX_W'($urandom_range(0, NODES - 1)), IDX_W'(i), 1'b0);
        push_word(REQ_COMPLETE, '0, IDX_W'(NODES - 1), 1'b0);
        push_word(REQ_COMPLETE, '1, IDX_W'(NODES - 1), 1'b0);

        // Random graphs: a handful of nodes (now and then most of them), edges that follow
        // the order of the pick list so the graph is mostly acyclic, then requests for the
        // picked nodes in random order, repeats included.
        noise_on = 1'b1;
        while (useful_words < ITEM_TARGET)
        begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(17, NODES) : $urandom_range(2, 12);
            for (int k = 0; k < n; k++)
                picks[k] = $urandom_range(0, NODES - 1);
            if ($urandom_range(0, 3) != 0)
                push_word(REQ_CLEAR, IDX_W'($urandom_range(0, NODES - 1)),
                          IDX_W'($urandom_range(0, NODES - 1)), $urandom_range(0, 5) == 0);
            edges = $urandom_range(0, 2 * n);
            for (int k = 0; k < edges; k++)
            begin
                a = $urandom_range(0, n - 2);
                b = $urandom_range(a + 1, n - 1);
                // A few edges point backwards, which may close a cycle that never completes.
                if ($urandom_range(0, 15) == 0)
                    push_word(REQ_EDGE, IDX_W'(picks[b]), IDX_W'(picks[a]), 1'b0);
                else
                    push_word(REQ_EDGE, IDX_W'(picks[a]), IDX_W'(picks[b]), 1'b0);
            end
            requests = n + $urandom_range(0, n / 2);
            for (int k = 0; k < requests; k++)
                push_word(REQ_COMPLETE, IDX_W'($urandom_range(0, NODES - 1)),
                          IDX_W'(picks[$urandom_range(0, n - 1)]), 1'b0);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Sender: bursts of random length with random gaps, some of them zero, so that long
        // back-to-back stretches occur as well. A word on offer stays until it is taken.
        sent       = 0;
        gap_left   = 0;
        burst_left = $urandom_range(1, 16);
        while (sent < stim.size())
        begin
            @(posedge clk);
            if (s_tvalid && s_tready)
            begin
                predict_release(stim[sent], answers, total);
                if (answers)
                    due_counts.push_back(stim[sent].known ? stim[sent].answer : total);
                sent++;
            end
            if (!(s_tvalid && !s_tready))
            begin
                if (sent == stim.size())
                begin
                    s_tvalid <= 1'b0;
                end
                else if (stim[sent].drain && due_counts.size() != 0)
                begin
                    s_tvalid <= 1'b0;
                end
                else if (gap_left > 0)
                begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end
                else
                begin
                    s_tvalid <= 1'b1;
                    s_tuser  <= stim[sent].kind;
                    s_tdata  <= {{(S_TDATA_W - 2 * IDX_W){1'b0}}, stim[sent].tgt,
                                 stim[sent].pre};
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 16);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                        if ($urandom_range(0, 19) == 0)
                            gap_left = $urandom_range(20, 40);
                    end
                end
            end
        end

        // Every word is in; wait for the remaining counts, then watch for strays.
        while (due_counts.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
